[rtl/mssb_pkg.sv]
// Shared constants for the multi-stack shared buffer.
package mssb_pkg;

    localparam int DEF_NUM_STACKS = 4;
    localparam int DEF_CAPACITY   = 64;

    localparam int DATA_W   = 32;
    localparam int SID_W    = 2;

    // Request codes carried in req_type.
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // Value reported by a pop that fails.
    localparam logic signed [DATA_W-1:0] POP_FAIL_VALUE = -32'sd1;

endpackage

[rtl/mssb_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface mssb_req_if
    import mssb_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [SID_W-1:0]         stack_id;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, output req_type, output stack_id, output push_value,
                    input ready);
    modport sink   (input valid, input req_type, input stack_id, input push_value,
                    output ready);
endinterface

interface mssb_rsp_if
    import mssb_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] pop_value;

    modport source (output valid, output ok, output pop_value, input ready);
    modport sink   (input valid, input ok, input pop_value, output ready);
endinterface

[rtl/mssb_entry_store.sv]
// Entry memory (value and link per entry) with fill-mark handling of the reset links.
module mssb_entry_store
    import mssb_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int PTR_W    = $clog2(CAPACITY + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_data,
    output logic [PTR_W-1:0]         rd_link,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic [PTR_W-1:0]         wr_link
);

    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    logic signed [DATA_W-1:0] data_mem [CAPACITY];
    logic [PTR_W-1:0]         link_mem [CAPACITY];

    logic signed [DATA_W-1:0] data_q_reg;
    logic [PTR_W-1:0]         link_q_reg;
    logic [PTR_W-1:0]         addr_q_reg;
    logic                     fresh_q_reg;

    // Entries at or above the fill mark were never written; their link is still i+1.
    logic [PTR_W-1:0]         fill_reg;
    logic [PTR_W-1:0]         fill_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_mem[wr_addr] <= wr_data;
            link_mem[wr_addr] <= wr_link;
        end
        if (rd_en)
        begin
            data_q_reg  <= data_mem[rd_addr];
            link_q_reg  <= link_mem[rd_addr];
            addr_q_reg  <= PTR_W'(rd_addr);
            fresh_q_reg <= PTR_W'(rd_addr) >= fill_reg;
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (PTR_W'(wr_addr) == fill_reg))
        begin
            fill_next = fill_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // The last entry's i+1 equals the null code, so no special case is needed.
    always_comb
    begin
        if (fresh_q_reg)
        begin
            rd_link = addr_q_reg + PTR_W'(1);
        end
        else if (link_q_reg < NIL)
        begin
            rd_link = link_q_reg;
        end
        else
        begin
            rd_link = NIL;
        end
    end

    assign rd_data = data_q_reg;

endmodule

[rtl/multi_stack_shared_buffer.sv]
// Top level: several LIFO stacks threaded as linked lists through one shared entry store.
//
// Each request on the req channel is a push or a pop on one of NUM_STACKS stacks; each
// produces exactly one beat on the rsp channel. Stacks and the free list are linked lists
// through a single entry memory of CAPACITY entries; stack tops sit in a small synchronous
// memory. One request is in flight at a time. A push reads the top memory and the entry at
// the free head together at acceptance, then writes both back; a pop reads its entry only
// after the top, because the entry read depends on the stack top that the top memory returns
// in the cycle after acceptance. A push on a full store returns ok=0, pop_value=0; a pop
// on an empty stack returns ok=0, pop_value=-1; a stack_id not below NUM_STACKS is rejected
// the same way. No clearing pass is needed after reset: stack tops carry valid bits and
// the reset links of the entry store are covered by a fill mark, so the block accepts a
// request as soon as reset is released. The response register lets a finished beat wait
// while the next request is accepted.
module multi_stack_shared_buffer
    import mssb_pkg::*;
#(
    parameter int NUM_STACKS = DEF_NUM_STACKS,
    parameter int CAPACITY   = DEF_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    mssb_req_if.sink    req,
    mssb_rsp_if.source  rsp
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int PTR_W  = $clog2(CAPACITY + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(CAPACITY);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_TOP  = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Request being worked on.
    logic                     is_pop_reg;
    logic [STK_W-1:0]         sid_reg;
    logic                     in_range_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [PTR_W-1:0]         idx_reg;
    logic                     top_vld_q_reg;

    // Stack tops: a memory plus one valid bit per stack.
    logic [PTR_W-1:0]         top_mem [NUM_STACKS];
    logic [PTR_W-1:0]         top_rdata_reg;
    logic [NUM_STACKS-1:0]    top_vld_reg;
    logic [PTR_W-1:0]         free_head_reg;

    // Response register.
    logic                     rsp_valid_reg;
    logic                     ok_reg;
    logic signed [DATA_W-1:0] pop_value_reg;

    logic                     req_beat;
    logic                     commit;
    logic [6:0]               sid_wide;
    logic [STK_W-1:0]         sid_in;
    logic                     in_range;
    logic [PTR_W-1:0]         top_eff;
    logic                     op_ok;

    logic                     ent_rd_en;
    logic [IDX_W-1:0]         ent_rd_addr;
    logic signed [DATA_W-1:0] ent_rd_data;
    logic [PTR_W-1:0]         ent_rd_link;
    logic                     ent_wr_en;
    logic signed [DATA_W-1:0] ent_wr_data;
    logic [PTR_W-1:0]         ent_wr_link;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_beat  = req.valid && req.ready;

    // Hold the op in the execute state until the response register has room.
    assign commit = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign sid_wide = 7'(req.stack_id);
    assign sid_in   = sid_wide[STK_W-1:0];
    assign in_range = sid_wide < 7'(NUM_STACKS);

    // Effective top of the addressed stack; an unset or corrupt top reads as null.
    assign top_eff = (top_vld_q_reg && (top_rdata_reg < NIL)) ? top_rdata_reg : NIL;

    assign op_ok = in_range_reg && (idx_reg < NIL);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_beat)
                begin
                    state_next = (req.req_type == REQ_POP) ? ST_TOP : ST_EXEC;
                end
            end
            ST_TOP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Entry reads: a push reads the free head at acceptance, a pop reads its top in the
    // ST_TOP state that follows.
    always_comb
    begin
        ent_rd_en   = 1'b0;
        ent_rd_addr = free_head_reg[IDX_W-1:0];
        if (req_beat && (req.req_type == REQ_PUSH))
        begin
            ent_rd_en = free_head_reg < NIL;
        end
        else if (state_reg == ST_TOP)
        begin
            ent_rd_en   = in_range_reg && (top_eff < NIL);
            ent_rd_addr = top_eff[IDX_W-1:0];
        end
    end

    assign ent_wr_en   = commit && op_ok;
    assign ent_wr_data = is_pop_reg ? ent_rd_data : val_reg;
    assign ent_wr_link = is_pop_reg ? free_head_reg : top_eff;

    mssb_entry_store #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .PTR_W    (PTR_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ent_rd_en),
        .rd_addr (ent_rd_addr),
        .rd_data (ent_rd_data),
        .rd_link (ent_rd_link),
        .wr_en   (ent_wr_en),
        .wr_addr (idx_reg[IDX_W-1:0]),
        .wr_data (ent_wr_data),
        .wr_link (ent_wr_link)
    );

    // Top memory: read at acceptance, written back at commit.
    always_ff @(posedge clk)
    begin
        if (ent_wr_en)
        begin
            top_mem[sid_reg] <= is_pop_reg ? ent_rd_link : idx_reg;
        end
        if (req_beat && in_range)
        begin
            top_rdata_reg <= top_mem[sid_in];
        end
    end

    // Payload of the op in flight.
    always_ff @(posedge clk)
    begin
        if (req_beat)
        begin
            is_pop_reg   <= (req.req_type == REQ_POP);
            sid_reg      <= sid_in;
            in_range_reg <= in_range;
            val_reg      <= req.push_value;
            idx_reg      <= free_head_reg;
        end
        else if (state_reg == ST_TOP)
        begin
            idx_reg <= top_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_vld_reg   <= '0;
            top_vld_q_reg <= 1'b0;
            free_head_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_beat)
            begin
                top_vld_q_reg <= in_range && top_vld_reg[sid_in];
            end
            if (ent_wr_en)
            begin
                top_vld_reg[sid_reg] <= 1'b1;
                // Advance the free head on push; return the popped entry on pop.
                free_head_reg <= is_pop_reg ? idx_reg : ent_rd_link;
            end
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            ok_reg <= op_ok;
            if (!is_pop_reg)
            begin
                pop_value_reg <= '0;
            end
            else if (op_ok)
            begin
                pop_value_reg <= ent_rd_data;
            end
            else
            begin
                pop_value_reg <= POP_FAIL_VALUE;
            end
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.ok        = ok_reg;
    assign rsp.pop_value = pop_value_reg;

endmodule
